[rtl/core/cmm_pkg.sv]
// Package for the complex matrix multiplier: field widths, register
// indexes, element kinds and the structs shared by the top level and the cells.
// No dependencies.
`default_nettype none

package cmm_pkg;

    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 37;
    localparam int IDX_OUT_W  = 4;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 5'd16;

    // Element kinds on the input channel
    localparam logic KIND_B = 1'b0;
    localparam logic KIND_A = 1'b1;

    // Complex accumulator value
    typedef struct packed {
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
    } cmm_cplx_t;

    // Per-cycle control of one accumulator cell
    typedef struct packed {
        logic shift;
        logic clr;
        logic add;
    } cmm_cell_ctl_t;

endpackage

`default_nettype wire

[rtl/core/cmm_in_if.sv]
// Input channel of the complex matrix multiplier: valid/ready plus one
// element (kind, real and imaginary part). Depends on cmm_pkg.
`default_nettype none

interface cmm_in_if;
    import cmm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [ELEM_W-1:0] elem_re;
    logic signed [ELEM_W-1:0] elem_im;

    modport source (output valid, output kind, output elem_re, output elem_im, input ready);
    modport sink   (input valid, input kind, input elem_re, input elem_im, output ready);
endinterface

`default_nettype wire

[rtl/core/cmm_out_if.sv]
// Output channel of the complex matrix multiplier: valid/ready plus one
// element of C with its row and column. Depends on cmm_pkg.
`default_nettype none

interface cmm_out_if;
    import cmm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] out_re;
    logic signed [ACC_W-1:0] out_im;
    logic [IDX_OUT_W-1:0]    out_row;
    logic [IDX_OUT_W-1:0]    out_col;
    logic                    last;

    modport source (output valid, output out_re, output out_im, output out_row,
                    output out_col, output last, input ready);
    modport sink   (input valid, input out_re, input out_im, input out_row,
                    input out_col, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/cmm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/cmm_cell.sv]
// One accumulator cell of the rotating ring: holds one complex column sum and
// takes its neighbor's value on every shift, optionally cleared and added to.
// Depends on cmm_pkg.
`default_nettype none

module cmm_cell (
    input  wire logic                   clk,
    input  wire cmm_pkg::cmm_cell_ctl_t ctl,
    input  wire cmm_pkg::cmm_cplx_t     nb,
    input  wire cmm_pkg::cmm_cplx_t     add,
    output cmm_pkg::cmm_cplx_t          acc
);
    import cmm_pkg::*;

    cmm_cplx_t acc_reg;
    cmm_cplx_t base;
    cmm_cplx_t acc_next;

    // Drop the incoming value on a clear, then add the product if enabled
    always_comb
    begin
        base = ctl.clr ? '0 : nb;
        acc_next.re = base.re + (ctl.add ? add.re : '0);
        acc_next.im = base.im + (ctl.add ? add.im : '0);
    end

    // Advance the ring
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

[rtl/core/complex_matrix_multiply.sv]
// Complex matrix multiplier C = A * B over Q1.15 elements with exact 37-bit
// sums. Depends on cmm_pkg, cmm_in_if, cmm_out_if, cmm_ram and cmm_cell.
//
// Load B first (inner_count x col_count, row-major, kind 0), then stream A
// (row-major, kind 1). A B element is stored while the input stays ready. For
// each A element B is read one entry per cycle for MAX_DIM column slots, and
// each complex product passes a three-stage multiply path into a ring of
// MAX_DIM accumulator cells that rotates once per slot. After the last A
// element of a row the ring rotates MAX_DIM more times to emit the col_count
// results of that C row, one per cycle while the sink is ready. Results are
// held in an output register, so a new element is taken while the final
// result of a row still waits. Dimension registers read as 1 when zero and as
// MAX_DIM when above it.
`default_nettype none

module complex_matrix_multiply #(
    parameter int MAX_DIM = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    cmm_in_if.sink                                   elem,
    cmm_out_if.source                                result,
    input  wire logic                                cfg_wr_en,
    input  wire logic [cmm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [cmm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import cmm_pkg::*;

    localparam int IW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int AW = $clog2(MAX_DIM * MAX_DIM);
    localparam int TW = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam logic [IW-1:0] J_LAST = IW'(MAX_DIM - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_EMIT} state_t;

    function automatic logic [DW-1:0] eff_dim(input logic [CFG_DATA_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (v == '0)
        begin
            return DW'(1);
        end
        else if (w > 32'(MAX_DIM))
        begin
            return DW'(MAX_DIM);
        end
        return DW'(v);
    endfunction

    function automatic logic [IDX_OUT_W-1:0] to_out_idx(input logic [IW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[IDX_OUT_W-1:0];
    endfunction

    state_t                  state_reg;
    logic [CFG_DATA_W-1:0]   row_cnt_reg, col_cnt_reg, inner_cnt_reg;
    logic [DW-1:0]           rows, cols, inner;
    logic [TW-1:0]           total;

    logic                    accept;
    logic                    accept_a, accept_b;

    logic [AW-1:0]           b_pos_reg, b_wr_pos, b_pos_next;
    logic [TW-1:0]           b_nxt;

    logic [IW-1:0]           a_row_reg, a_inner_reg;
    logic [IW-1:0]           row_cur, inr_cur, a_row_next, a_inner_next;
    logic [DW-1:0]           row_inc, inr_inc;
    logic                    row_done;
    logic [AW-1:0]           base_next;

    logic signed [ELEM_W-1:0] a_re_reg, a_im_reg;
    logic [AW-1:0]           base_reg;
    logic                    first_reg, row_done_reg;
    logic [IW-1:0]           row_hold_reg;

    logic [IW-1:0]           j_reg, e_reg;
    logic [2*ELEM_W-1:0]     rdata;
    logic signed [ELEM_W-1:0] b_re, b_im;

    logic                    v1_reg, v2_reg, v3_reg;
    logic                    inr1_reg, inr2_reg, inr3_reg;
    logic                    lb1_reg, lb2_reg, lb3_reg;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    cmm_cplx_t               prod_reg;

    logic                    emit_adv, emit_in, emit_last;
    cmm_cell_ctl_t           ring_ctl, pass_ctl;
    cmm_cplx_t               acc_w [MAX_DIM];

    logic                    out_valid_reg, out_last_reg;
    logic signed [ACC_W-1:0] out_re_reg, out_im_reg;
    logic [IDX_OUT_W-1:0]    out_row_reg, out_col_reg;

    // Effective dimensions and the size of B
    assign rows  = eff_dim(row_cnt_reg);
    assign cols  = eff_dim(col_cnt_reg);
    assign inner = eff_dim(inner_cnt_reg);
    assign total = TW'(inner) * TW'(cols);

    // Input handshake
    assign elem.ready = (state_reg == ST_IDLE);
    assign accept     = elem.valid && elem.ready;
    assign accept_a   = accept && (elem.kind == KIND_A);
    assign accept_b   = accept && (elem.kind == KIND_B);

    // B write position, restarted when stale
    always_comb
    begin
        b_wr_pos   = (TW'(b_pos_reg) >= total) ? '0 : b_pos_reg;
        b_nxt      = TW'(b_wr_pos) + TW'(1);
        b_pos_next = (b_nxt >= total) ? '0 : b_nxt[AW-1:0];
    end

    // A row and inner position, restarted when stale
    always_comb
    begin
        row_cur      = (DW'(a_row_reg) >= rows) ? '0 : a_row_reg;
        inr_cur      = (DW'(a_inner_reg) >= inner) ? '0 : a_inner_reg;
        inr_inc      = DW'(inr_cur) + DW'(1);
        row_inc      = DW'(row_cur) + DW'(1);
        row_done     = (inr_inc == inner);
        a_inner_next = row_done ? '0 : inr_inc[IW-1:0];
        a_row_next   = row_done ? ((row_inc >= rows) ? '0 : row_inc[IW-1:0]) : row_cur;
        base_next    = AW'(TW'(inr_cur) * TW'(cols));
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg   <= DIM_RESET;
            col_cnt_reg   <= DIM_RESET;
            inner_cnt_reg <= DIM_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ROW_COUNT:   row_cnt_reg   <= cfg_data;
                REG_COL_COUNT:   col_cnt_reg   <= cfg_data;
                REG_INNER_COUNT: inner_cnt_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_pos_reg   <= '0;
            a_row_reg   <= '0;
            a_inner_reg <= '0;
        end
        else
        begin
            if (accept_b)
            begin
                b_pos_reg <= b_pos_next;
            end
            if (accept_a)
            begin
                a_row_reg   <= a_row_next;
                a_inner_reg <= a_inner_next;
            end
        end
    end

    // Hold the A element for the whole sweep
    always_ff @(posedge clk)
    begin
        if (accept_a)
        begin
            a_re_reg     <= elem.elem_re;
            a_im_reg     <= elem.elem_im;
            base_reg     <= base_next;
            first_reg    <= (inr_cur == '0);
            row_done_reg <= row_done;
            row_hold_reg <= row_cur;
        end
    end

    // B storage
    cmm_ram #(
        .WIDTH (2 * ELEM_W),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_b_ram (
        .clk   (clk),
        .we    (accept_b),
        .waddr (b_wr_pos),
        .wdata ({elem.elem_re, elem.elem_im}),
        .re    (state_reg == ST_ISSUE),
        .raddr (base_reg + AW'(j_reg)),
        .rdata (rdata)
    );

    assign b_re = signed'(rdata[2*ELEM_W-1:ELEM_W]);
    assign b_im = signed'(rdata[ELEM_W-1:0]);

    // Pipeline tags: slot valid, column in range, final slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            inr1_reg <= 1'b0;
            inr2_reg <= 1'b0;
            inr3_reg <= 1'b0;
            lb1_reg  <= 1'b0;
            lb2_reg  <= 1'b0;
            lb3_reg  <= 1'b0;
        end
        else
        begin
            v1_reg   <= (state_reg == ST_ISSUE);
            inr1_reg <= (DW'(j_reg) < cols);
            lb1_reg  <= (j_reg == J_LAST);
            v2_reg   <= v1_reg;
            inr2_reg <= inr1_reg;
            lb2_reg  <= lb1_reg;
            v3_reg   <= v2_reg;
            inr3_reg <= inr2_reg;
            lb3_reg  <= lb2_reg;
        end
    end

    // Complex product: partial products, then combine
    always_ff @(posedge clk)
    begin
        p_rr_reg    <= a_re_reg * b_re;
        p_ii_reg    <= a_im_reg * b_im;
        p_ri_reg    <= a_re_reg * b_im;
        p_ir_reg    <= a_im_reg * b_re;
        prod_reg.re <= ACC_W'(p_rr_reg) - ACC_W'(p_ii_reg);
        prod_reg.im <= ACC_W'(p_ri_reg) + ACC_W'(p_ir_reg);
    end

    // Emission step
    assign emit_adv  = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);
    assign emit_in   = (DW'(e_reg) < cols);
    assign emit_last = ((DW'(e_reg) + DW'(1)) == cols);

    // Ring control: products enter at the tail, emission just rotates
    assign ring_ctl.shift = v3_reg || emit_adv;
    assign ring_ctl.clr   = v3_reg && first_reg;
    assign ring_ctl.add   = v3_reg && inr3_reg;
    assign pass_ctl.shift = ring_ctl.shift;
    assign pass_ctl.clr   = 1'b0;
    assign pass_ctl.add   = 1'b0;

    // Ring of accumulator cells; cell 0 holds the column of the current slot
    for (genvar k = 0; k < MAX_DIM; k++)
    begin : g_cell
        if (k == MAX_DIM - 1)
        begin : g_tail
            cmm_cell u_cell (
                .clk (clk),
                .ctl (ring_ctl),
                .nb  (acc_w[0]),
                .add (prod_reg),
                .acc (acc_w[k])
            );
        end
        else
        begin : g_body
            cmm_cell u_cell (
                .clk (clk),
                .ctl (pass_ctl),
                .nb  (acc_w[k + 1]),
                .add (prod_reg),
                .acc (acc_w[k])
            );
        end
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            j_reg         <= '0;
            e_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_re_reg    <= '0;
            out_im_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
        end
        else
        begin
            // Drop a taken result unless the emission step refills the register
            if (result.ready && !emit_adv)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept_a)
                    begin
                        state_reg <= ST_ISSUE;
                        j_reg     <= '0;
                    end
                end
                ST_ISSUE:
                begin
                    j_reg <= j_reg + IW'(1);
                    if (j_reg == J_LAST)
                    begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    if (v3_reg && lb3_reg)
                    begin
                        if (row_done_reg)
                        begin
                            state_reg <= ST_EMIT;
                            e_reg     <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (emit_adv)
                    begin
                        out_valid_reg <= emit_in;
                        out_last_reg  <= emit_last;
                        out_re_reg    <= acc_w[0].re;
                        out_im_reg    <= acc_w[0].im;
                        out_row_reg   <= to_out_idx(row_hold_reg);
                        out_col_reg   <= to_out_idx(e_reg);
                        e_reg         <= e_reg + IW'(1);
                        if (e_reg == J_LAST)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.out_re  = out_re_reg;
    assign result.out_im  = out_im_reg;
    assign result.out_row = out_row_reg;
    assign result.out_col = out_col_reg;
    assign result.last    = out_last_reg;

    // Emission never overlaps products still in flight
    a_emit_no_products: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !(v1_reg || v2_reg || v3_reg))
        else $error("ring emission overlaps product pipeline");

    // A new result appears only from the emission step
    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside emission");

    // The final product slot lands while the sequencer waits for it
    a_last_slot_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && lb3_reg) |-> (state_reg == ST_WAIT))
        else $error("final product slot outside wait state");

    // A B load leaves the sequencer in the idle state
    a_b_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        accept_b |=> (state_reg == ST_IDLE))
        else $error("B load left the idle state");

endmodule

`default_nettype wire
